// ----- rtl/sbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, constants and helpers for the Salsa20/8 BlockMix block.
// ----------------------------------------------------------------------------
package sbm_pkg;

	localparam int ROUNDS  = 8;
	localparam int DROUNDS = ROUNDS / 2;
	localparam int DR_W    = $clog2(DROUNDS + 1);
	localparam int ROWS    = 8;
	localparam int HALF    = ROWS / 2;
	localparam int LANES   = 4;

	typedef logic [31:0] word_t;
	typedef word_t [LANES-1:0] row_t;
	typedef row_t [HALF-1:0] half_t;

	typedef enum logic [1:0] {
		ROT_7  = 2'd0,
		ROT_9  = 2'd1,
		ROT_13 = 2'd2,
		ROT_18 = 2'd3
	} rot_sel_t;

	typedef struct packed {
		logic [1:0] dst;
		logic [1:0] a;
		logic [1:0] b;
		rot_sel_t   rot;
	} step_plan_t;

	typedef struct packed {
		logic [31:0] word_lane0;
		logic [31:0] word_lane1;
		logic [31:0] word_lane2;
		logic [31:0] word_lane3;
	} row_word_t;

	typedef struct packed {
		logic [31:0] out_lane0;
		logic [31:0] out_lane1;
		logic [31:0] out_lane2;
		logic [31:0] out_lane3;
		logic        is_last;
	} mix_word_t;

	typedef struct packed {
		logic start;
	} core_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	function automatic word_t rotl(word_t x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic row_t lane_rot(row_t v, logic [1:0] n);
		row_t       t;
		logic [1:0] idx;
		for (int i = 0; i < LANES; i++) begin
			idx  = 2'(i) + n;
			t[i] = v[idx];
		end
		return t;
	endfunction

	function automatic step_plan_t step_plan(logic [2:0] s);
		step_plan_t p;
		case (s)
			3'd0: p = '{dst: 2'd1, a: 2'd0, b: 2'd3, rot: ROT_7};
			3'd1: p = '{dst: 2'd2, a: 2'd1, b: 2'd0, rot: ROT_9};
			3'd2: p = '{dst: 2'd3, a: 2'd2, b: 2'd1, rot: ROT_13};
			3'd3: p = '{dst: 2'd0, a: 2'd3, b: 2'd2, rot: ROT_18};
			3'd4: p = '{dst: 2'd3, a: 2'd0, b: 2'd1, rot: ROT_7};
			3'd5: p = '{dst: 2'd2, a: 2'd3, b: 2'd0, rot: ROT_9};
			3'd6: p = '{dst: 2'd1, a: 2'd2, b: 2'd3, rot: ROT_13};
			3'd7: p = '{dst: 2'd0, a: 2'd1, b: 2'd2, rot: ROT_18};
			default: p = '{dst: 2'd1, a: 2'd0, b: 2'd3, rot: ROT_7};
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/sbm_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_lane
// One lane of the Salsa20 step: d XOR rotl(a + b, amount).
// ----------------------------------------------------------------------------
module sbm_lane (
	input  sbm_pkg::word_t    d,
	input  sbm_pkg::word_t    a,
	input  sbm_pkg::word_t    b,
	input  sbm_pkg::rot_sel_t rot,
	output sbm_pkg::word_t    y
);

	sbm_pkg::word_t sum;
	sbm_pkg::word_t rotated;

	assign sum = a + b;

	always_comb begin
		case (rot)
			sbm_pkg::ROT_7:  rotated = sbm_pkg::rotl(sum, 7);
			sbm_pkg::ROT_9:  rotated = sbm_pkg::rotl(sum, 9);
			sbm_pkg::ROT_13: rotated = sbm_pkg::rotl(sum, 13);
			sbm_pkg::ROT_18: rotated = sbm_pkg::rotl(sum, 18);
			default:         rotated = sum;
		endcase
	end

	assign y = d ^ rotated;

endmodule

// ----- rtl/sbm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_core
// Salsa20 core: four lanes apply one step per cycle to the working matrix,
// then the feed-forward stage merges the lanes back with the input matrix.
// ----------------------------------------------------------------------------
module sbm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  sbm_pkg::core_ctrl_t ctrl,
	input  sbm_pkg::half_t      x_in,
	output sbm_pkg::core_stat_t stat,
	output sbm_pkg::half_t      result
);

	sbm_pkg::half_t             x_q;
	sbm_pkg::half_t             q_q;
	sbm_pkg::half_t             qr;
	sbm_pkg::half_t             q_next;
	sbm_pkg::row_t              lane_y;
	sbm_pkg::step_plan_t        plan;
	logic [2:0]                 step_q;
	logic [sbm_pkg::DR_W-1:0]   dr_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       last_step;

	assign plan      = sbm_pkg::step_plan(step_q);
	assign last_step = (step_q == 3'd7) && (dr_q == sbm_pkg::DR_W'(sbm_pkg::DROUNDS - 1));

	always_comb begin
		qr = q_q;
		if (step_q == 3'd0) begin
			qr[1] = sbm_pkg::lane_rot(q_q[1], 2'd1);
			qr[2] = sbm_pkg::lane_rot(q_q[2], 2'd2);
			qr[3] = sbm_pkg::lane_rot(q_q[3], 2'd3);
		end else if (step_q == 3'd4) begin
			qr[3] = sbm_pkg::lane_rot(q_q[3], 2'd1);
			qr[2] = sbm_pkg::lane_rot(q_q[2], 2'd2);
			qr[1] = sbm_pkg::lane_rot(q_q[1], 2'd3);
		end
	end

	for (genvar g = 0; g < sbm_pkg::LANES; g++) begin : g_lane
		sbm_lane u_lane (
			.d   (qr[plan.dst][g]),
			.a   (qr[plan.a][g]),
			.b   (qr[plan.b][g]),
			.rot (plan.rot),
			.y   (lane_y[g])
		);
	end

	always_comb begin
		q_next           = qr;
		q_next[plan.dst] = lane_y;
	end

	always_comb begin
		for (int i = 0; i < sbm_pkg::LANES; i++) begin
			result[0][i] = x_q[0][i] + q_q[0][i];
			result[1][i] = x_q[1][i] + q_q[3][i];
			result[2][i] = x_q[2][i] + q_q[2][i];
			result[3][i] = x_q[3][i] + q_q[1][i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= x_in;
			q_q <= x_in;
		end else if (busy_q) begin
			q_q <= q_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			dr_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				dr_q   <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					dr_q <= dr_q + sbm_pkg::DR_W'(1);
				end
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/salsa20_8_block_mix_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salsa20_8_block_mix_top
// scrypt BlockMix with two Salsa20/8 passes over a row-streamed 1024-bit block.
// ----------------------------------------------------------------------------
// Words arrive as rows of four 32-bit lanes, eight rows per block. Rows one
// to seven are taken at one per cycle and produce nothing. After the eighth
// the block replaces the first half with Salsa20 of both halves XORed, then
// the second half with Salsa20 of the second half XOR the new first half,
// and sends the eight result rows in order, is_last set on the eighth. Each
// pass runs on one four-lane step unit that does one add/rotate/XOR row per
// cycle. row_stall stays high from the eighth row until the last result row
// has been loaded into the output register.
// ----------------------------------------------------------------------------
module salsa20_8_block_mix_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_valid,
	output logic               row_stall,
	input  sbm_pkg::row_word_t row,
	output logic               mix_valid,
	input  logic               mix_stall,
	output sbm_pkg::mix_word_t mix
);

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_RUN0 = 4'b0010,
		ST_RUN1 = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                  state_q;
	sbm_pkg::row_t           rows_q [sbm_pkg::ROWS];
	sbm_pkg::row_t           row_in;
	sbm_pkg::half_t          x_in;
	sbm_pkg::half_t          result;
	sbm_pkg::core_ctrl_t     core_ctrl;
	sbm_pkg::core_stat_t     core_stat;
	sbm_pkg::mix_word_t      out_q;
	logic                    out_valid_q;
	logic [2:0]              row_cnt_q;
	logic [2:0]              emit_q;
	logic                    start_q;
	logic                    row_take;
	logic                    out_load;

	assign row_stall = (state_q != ST_LOAD);
	assign row_take  = row_valid && !row_stall;
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !mix_stall);

	assign row_in[0] = row.word_lane0;
	assign row_in[1] = row.word_lane1;
	assign row_in[2] = row.word_lane2;
	assign row_in[3] = row.word_lane3;

	always_comb begin
		for (int h = 0; h < sbm_pkg::HALF; h++) begin
			x_in[h] = rows_q[h] ^ rows_q[h + sbm_pkg::HALF];
		end
	end

	assign core_ctrl.start = start_q;

	sbm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (core_ctrl),
		.x_in   (x_in),
		.stat   (core_stat),
		.result (result)
	);

	always_ff @(posedge clk) begin
		if (row_take) begin
			rows_q[row_cnt_q] <= row_in;
		end
		if (core_stat.done && state_q == ST_RUN0) begin
			for (int h = 0; h < sbm_pkg::HALF; h++) begin
				rows_q[h] <= result[h];
			end
		end
		if (core_stat.done && state_q == ST_RUN1) begin
			for (int h = 0; h < sbm_pkg::HALF; h++) begin
				rows_q[h + sbm_pkg::HALF] <= result[h];
			end
		end
		if (out_load) begin
			out_q.out_lane0 <= rows_q[emit_q][0];
			out_q.out_lane1 <= rows_q[emit_q][1];
			out_q.out_lane2 <= rows_q[emit_q][2];
			out_q.out_lane3 <= rows_q[emit_q][3];
			out_q.is_last   <= (emit_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			row_cnt_q   <= '0;
			emit_q      <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!mix_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (row_take) begin
						row_cnt_q <= row_cnt_q + 3'd1;
						if (row_cnt_q == 3'd7) begin
							state_q <= ST_RUN0;
							start_q <= 1'b1;
						end
					end
				end
				ST_RUN0: begin
					if (core_stat.done) begin
						state_q <= ST_RUN1;
						start_q <= 1'b1;
					end
				end
				ST_RUN1: begin
					if (core_stat.done) begin
						state_q <= ST_EMIT;
						emit_q  <= '0;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign mix_valid = out_valid_q;
	assign mix       = out_q;

	a_rise_from_emit : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mix_valid) |-> $past(state_q == ST_EMIT))
		else $error("result word appeared outside the emit phase");

	a_busy_in_run : assert property (@(posedge clk) disable iff (!arst_n)
		core_stat.busy |-> (state_q == ST_RUN0 || state_q == ST_RUN1))
		else $error("core running outside a mix pass");

	a_emit_after_done : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> $past(core_stat.done))
		else $error("emit phase entered without a finished second pass");

	a_no_start_while_busy : assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !core_stat.busy)
		else $error("core restarted while still running");

endmodule
